// ===== rtl/core/ptt_pkg.sv =====
// Shared types and constants of the periodic timer table.
package ptt_pkg;

    localparam int MAX_TIMERS  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int ID_BITS     = 16;
    localparam int IDX_W       = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W       = $clog2(MAX_TIMERS + 1);
    localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        KIND_SCHEDULE = 2'd0,
        KIND_CANCEL   = 2'd1,
        KIND_TICK     = 2'd2,
        KIND_CLEAR    = 2'd3
    } t_kind;

    localparam logic RES_REPLY = 1'b0;
    localparam logic RES_FIRED = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  event_code;
        logic [31:0] interval_ms;
        logic [15:0] target_id;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] assigned_id;
        logic        table_full;
        logic [7:0]  fired_event;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [7:0]         event_code;
        logic [31:0]        period;
        logic [31:0]        last_fire;
    } t_entry;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic scan_finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_end;
    } t_dp_sts;

endpackage

// ===== rtl/core/periodic_timer_table.sv =====
// Top level of the periodic timer table: controller and datapath.
// An item is taken when i_start is high and o_busy is low. Schedule and clear leave o_busy
// low, so the next item can follow at once; a schedule reply appears on o_out, with
// o_valid high, in the cycle after the item is taken. Cancel and tick walk the table
// one entry per cycle through the single read port of the entry memory and keep o_busy
// high while they do. Fired events come out in table order, at most one per cycle, each
// valid for exactly one cycle; the receiver cannot stall them, and last_of_run marks the
// last result of each item. The last fired event of a tick comes out in the first cycle
// with o_busy low again. Cancel, clear and a tick with nothing due give no result.
module periodic_timer_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  ptt_pkg::t_in_item  i_in,
    output logic               o_busy,
    output logic               o_valid,
    output ptt_pkg::t_out_item o_out
);

    ptt_pkg::t_ctl_cmd cmd;
    ptt_pkg::t_dp_sts  sts;

    ptt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_kind  (i_in.kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    ptt_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/core/ptt_ctrl.sv =====
// Controller state machine of the periodic timer table.
module ptt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_kind,
    input  ptt_pkg::t_dp_sts  i_sts,
    output ptt_pkg::t_ctl_cmd o_cmd,
    output logic              o_busy
);

    ptt_pkg::t_state r_state;
    ptt_pkg::t_state n_state;
    logic            accept;

    assign accept = i_start && (r_state == ptt_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptt_pkg::ST_IDLE: begin
                if (accept && (i_kind == ptt_pkg::KIND_CANCEL || i_kind == ptt_pkg::KIND_TICK)) begin
                    n_state = ptt_pkg::ST_SCAN;
                end
            end
            ptt_pkg::ST_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = ptt_pkg::ST_IDLE;
                end
            end
            default: n_state = ptt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.accept      = accept;
        o_busy            = 1'b0;
        unique case (r_state)
            ptt_pkg::ST_IDLE: o_busy = 1'b0;
            ptt_pkg::ST_SCAN: begin
                o_busy            = 1'b1;
                o_cmd.scan_step   = !i_sts.scan_end;
                o_cmd.scan_finish = i_sts.scan_end;
            end
            default: o_busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/ptt_datapath.sv =====
// Datapath of the periodic timer table: entry memory, counters, scan and result registers.
module ptt_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptt_pkg::t_ctl_cmd  i_cmd,
    input  ptt_pkg::t_in_item  i_in,
    output ptt_pkg::t_dp_sts   o_sts,
    output logic               o_valid,
    output ptt_pkg::t_out_item o_out
);

    ptt_pkg::t_entry mem [ptt_pkg::MAX_TIMERS];
    ptt_pkg::t_entry r_rd;

    // Control registers.
    logic [ptt_pkg::CNT_W-1:0]   r_count, n_count;
    logic [ptt_pkg::ID_BITS-1:0] r_next_id, n_next_id;
    logic [ptt_pkg::CNT_W-1:0]   r_idx, n_idx;
    logic                        r_vld, n_vld;
    logic                        r_found, n_found;
    logic [ptt_pkg::FIRE_W-1:0]  r_nfire, n_nfire;
    logic                        r_pend_vld, n_pend_vld;
    logic                        r_out_vld, n_out_vld;
    logic [1:0]                  r_kind;

    // Payload registers.
    logic [ptt_pkg::IDX_W-1:0]   r_eidx;
    logic [31:0]                 r_now;
    logic [15:0]                 r_target;
    logic [7:0]                  r_pend_ev;
    ptt_pkg::t_out_item          r_out, n_out;

    logic                        sched_req, sched_ok, sched_full;
    logic                        is_tick, is_cancel;
    logic                        due, fire, match, shift;
    logic                        issue;
    logic [ptt_pkg::ID_BITS-1:0] id_inc;
    logic                        we;
    logic [ptt_pkg::IDX_W-1:0]   waddr;
    ptt_pkg::t_entry             wdata;

    assign sched_req  = i_cmd.accept && (i_in.kind == ptt_pkg::KIND_SCHEDULE)
                        && (i_in.interval_ms != 32'd0);
    assign sched_ok   = sched_req && (r_count < ptt_pkg::CNT_W'(ptt_pkg::MAX_TIMERS));
    assign sched_full = sched_req && !sched_ok;

    assign is_tick   = (r_kind == ptt_pkg::KIND_TICK);
    assign is_cancel = (r_kind == ptt_pkg::KIND_CANCEL);

    // Elapsed time wraps at 32 bits, so the unsigned difference is the age.
    assign due   = (r_now - r_rd.last_fire) >= r_rd.period;
    assign fire  = i_cmd.scan_step && r_vld && is_tick && due
                   && (r_nfire < ptt_pkg::FIRE_W'(ptt_pkg::MAX_RESULTS));
    assign match = i_cmd.scan_step && r_vld && is_cancel && !r_found
                   && (32'(r_rd.id) == 32'(r_target));
    // Once the cancelled entry is found, each later entry moves down one place.
    assign shift = i_cmd.scan_step && r_vld && is_cancel && r_found;
    assign issue = i_cmd.scan_step && (r_idx < r_count);

    assign id_inc = r_next_id + ptt_pkg::ID_BITS'(1);

    always_comb begin
        we    = 1'b0;
        waddr = r_eidx;
        wdata = r_rd;
        if (sched_ok) begin
            we               = 1'b1;
            waddr            = r_count[ptt_pkg::IDX_W-1:0];
            wdata.id         = r_next_id;
            wdata.event_code = i_in.event_code;
            wdata.period     = i_in.interval_ms;
            wdata.last_fire  = i_in.now_ms;
        end else if (fire) begin
            we              = 1'b1;
            wdata.last_fire = r_now;
        end else if (shift) begin
            we    = 1'b1;
            waddr = r_eidx - ptt_pkg::IDX_W'(1);
        end
    end

    always_comb begin
        n_count    = r_count;
        n_next_id  = r_next_id;
        n_idx      = r_idx;
        n_vld      = r_vld;
        n_found    = r_found;
        n_nfire    = r_nfire;
        n_pend_vld = r_pend_vld;
        n_out_vld  = 1'b0;
        n_out      = r_out;

        if (i_cmd.accept) begin
            n_idx      = '0;
            n_vld      = 1'b0;
            n_found    = 1'b0;
            n_nfire    = '0;
            n_pend_vld = 1'b0;
            if (i_in.kind == ptt_pkg::KIND_SCHEDULE) begin
                n_out_vld         = 1'b1;
                n_out.result_kind = ptt_pkg::RES_REPLY;
                n_out.assigned_id = sched_ok ? 16'(r_next_id) : 16'd0;
                n_out.table_full  = sched_full;
                n_out.fired_event = 8'd0;
                n_out.last_of_run = 1'b1;
            end
            if (i_in.kind == ptt_pkg::KIND_CLEAR) begin
                n_count   = '0;
                n_next_id = ptt_pkg::ID_BITS'(1);
            end
            if (sched_ok) begin
                n_count   = r_count + ptt_pkg::CNT_W'(1);
                n_next_id = (id_inc == '0) ? ptt_pkg::ID_BITS'(1) : id_inc;
            end
        end

        if (i_cmd.scan_step) begin
            n_vld = issue;
            if (issue) begin
                n_idx = r_idx + ptt_pkg::CNT_W'(1);
            end
            if (match) begin
                n_found = 1'b1;
            end
            // A fired event is held back one find, so the last one can be flagged.
            if (fire) begin
                n_nfire    = r_nfire + ptt_pkg::FIRE_W'(1);
                n_pend_vld = 1'b1;
                if (r_pend_vld) begin
                    n_out_vld         = 1'b1;
                    n_out.result_kind = ptt_pkg::RES_FIRED;
                    n_out.assigned_id = 16'd0;
                    n_out.table_full  = 1'b0;
                    n_out.fired_event = r_pend_ev;
                    n_out.last_of_run = 1'b0;
                end
            end
        end

        if (i_cmd.scan_finish) begin
            n_pend_vld = 1'b0;
            if (r_pend_vld) begin
                n_out_vld         = 1'b1;
                n_out.result_kind = ptt_pkg::RES_FIRED;
                n_out.assigned_id = 16'd0;
                n_out.table_full  = 1'b0;
                n_out.fired_event = r_pend_ev;
                n_out.last_of_run = 1'b1;
            end
            if (is_cancel && r_found) begin
                n_count = r_count - ptt_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_next_id  <= ptt_pkg::ID_BITS'(1);
            r_idx      <= '0;
            r_vld      <= 1'b0;
            r_found    <= 1'b0;
            r_nfire    <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_kind     <= ptt_pkg::KIND_SCHEDULE;
        end else begin
            r_count    <= n_count;
            r_next_id  <= n_next_id;
            r_idx      <= n_idx;
            r_vld      <= n_vld;
            r_found    <= n_found;
            r_nfire    <= n_nfire;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            if (i_cmd.accept) begin
                r_kind <= i_in.kind;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_cmd.accept) begin
            r_now    <= i_in.now_ms;
            r_target <= i_in.target_id;
        end
        if (issue) begin
            r_eidx <= r_idx[ptt_pkg::IDX_W-1:0];
        end
        if (fire) begin
            r_pend_ev <= r_rd.event_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[r_idx[ptt_pkg::IDX_W-1:0]];
    end

    assign o_sts.scan_end = (r_idx >= r_count) && !r_vld;
    assign o_valid        = r_out_vld;
    assign o_out          = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ptt_pkg::CNT_W'(ptt_pkg::MAX_TIMERS))
        else $error("entry count beyond table size");

    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != '0)
        else $error("id counter holds zero");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> r_idx <= r_count)
        else $error("scan index passed entry count");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_finish && r_pend_vld |=> r_out_vld && r_out.last_of_run)
        else $error("held fired event not flushed as last of run");

    a_no_fire_on_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step && is_cancel |-> !fire && !r_pend_vld)
        else $error("fired event during cancel");

endmodule

// ===== verif/periodic_timer_table_test.sv =====
// Self-checking testbench of the periodic timer table: directed cases and random traffic.
module periodic_timer_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptt_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = MAX_TIMERS + 4;
    localparam int RANDOM_ITEMS = 340;
    localparam int MAX_REPORTS  = 40;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_start = 1'b0;
    t_in_item  i_in    = '0;
    logic      o_busy;
    logic      o_valid;
    t_out_item o_out;

    periodic_timer_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    // Shadow copy of the timer table, kept in insertion order.
    int          tbl_count   = 0;
    logic [15:0] tbl_next_id = 16'd1;
    logic [15:0] tbl_id     [MAX_TIMERS];
    logic [7:0]  tbl_evt    [MAX_TIMERS];
    logic [31:0] tbl_period [MAX_TIMERS];
    logic [31:0] tbl_last   [MAX_TIMERS];

    t_out_item   awaited_results [$];
    int          error_count     = 0;
    int          items_sent      = 0;
    int          results_checked = 0;
    int          full_rejects    = 0;
    int          fired_total     = 0;
    int          idle_cycles     = 0;
    bit          sender_idles    = 1'b1;
    logic [31:0] sim_now;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void enqueue_result(t_out_item r);
        awaited_results.insert(awaited_results.size(), r);
    endfunction

    function automatic void predict_timer_results(t_in_item it);
        t_out_item   r;
        logic [31:0] elapsed;
        int          fired;
        int          hit;
        int          i;
        r     = '0;
        fired = 0;
        hit   = -1;
        case (t_kind'(it.kind))
            KIND_SCHEDULE: begin
                r.result_kind = RES_REPLY;
                r.last_of_run = 1'b1;
                if (it.interval_ms != 32'd0) begin
                    if (tbl_count >= MAX_TIMERS) begin
                        r.table_full = 1'b1;
                        full_rejects++;
                    end else begin
                        r.assigned_id         = tbl_next_id;
                        tbl_id[tbl_count]     = tbl_next_id;
                        tbl_evt[tbl_count]    = it.event_code;
                        tbl_period[tbl_count] = it.interval_ms;
                        tbl_last[tbl_count]   = it.now_ms;
                        tbl_count++;
                        tbl_next_id = tbl_next_id + 16'd1;
                        if (tbl_next_id == 16'd0) tbl_next_id = 16'd1;
                    end
                end
                enqueue_result(r);
            end
            KIND_CANCEL: begin
                for (i = 0; i < tbl_count; i++) begin
                    if (hit < 0 && tbl_id[i] == it.target_id) hit = i;
                end
                if (hit >= 0) begin
                    for (i = hit; i < tbl_count - 1; i++) begin
                        tbl_id[i]     = tbl_id[i + 1];
                        tbl_evt[i]    = tbl_evt[i + 1];
                        tbl_period[i] = tbl_period[i + 1];
                        tbl_last[i]   = tbl_last[i + 1];
                    end
                    tbl_count--;
                end
            end
            KIND_TICK: begin
                for (i = 0; i < tbl_count && fired < MAX_RESULTS; i++) begin
                    // Elapsed time wraps at 32 bits, like the millisecond counter.
                    elapsed = it.now_ms - tbl_last[i];
                    if (elapsed >= tbl_period[i]) begin
                        tbl_last[i]   = it.now_ms;
                        r.result_kind = RES_FIRED;
                        r.fired_event = tbl_evt[i];
                        enqueue_result(r);
                        fired++;
                    end
                end
                if (fired > 0) awaited_results[awaited_results.size() - 1].last_of_run = 1'b1;
                fired_total += fired;
            end
            default: begin
                tbl_count   = 0;
                tbl_next_id = 16'd1;
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!sender_idles || roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("[%0t] %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    // Start stays high into the next item when no gap follows.
    task automatic send_item(input t_kind kind, input logic [7:0] evt,
                             input logic [31:0] interval, input logic [15:0] target,
                             input logic [31:0] now);
        t_in_item it;
        int       gap;
        it.kind        = kind;
        it.event_code  = evt;
        it.interval_ms = interval;
        it.target_id   = target;
        it.now_ms      = now;
        gap            = pick_gap();
        i_in    <= it;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predict_timer_results(it);
        items_sent++;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Checked at the falling edge so the result check of the rising edge has already run.
    task automatic drain_results();
        i_start <= 1'b0;
        do @(negedge i_clk); while (awaited_results.size() != 0 || o_busy !== 1'b0);
        @(posedge i_clk);
    endtask

    task automatic test_schedule_and_reject();
        send_item(KIND_SCHEDULE, 8'h5A, 32'd0, 16'hFFFF, 32'h1234_5678);
        send_item(KIND_SCHEDULE, 8'hFF, 32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFF);
        send_item(KIND_SCHEDULE, 8'h00, 32'd1, 16'hFFFF, 32'hFFFF_FFF0);
        send_item(KIND_SCHEDULE, 8'hA5, 32'h20, 16'h0000, 32'hFFFF_FFF0);
    endtask

    // The time wraps past zero; entries also fire when elapsed exactly equals their interval.
    task automatic test_tick_elapsed();
        send_item(KIND_TICK, 8'h00, 32'd0, 16'd0, 32'h0000_000F);
        send_item(KIND_TICK, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0010);
        send_item(KIND_TICK, 8'h00, 32'd0, 16'd0, 32'hFFFF_FFFE);
    endtask

    task automatic test_cancel_and_full();
        int i;
        send_item(KIND_CANCEL, 8'h00, 32'd0, 16'h7777, 32'd0);
        send_item(KIND_CANCEL, 8'h00, 32'd0, 16'd1, 32'd0);
        for (i = 0; i < MAX_TIMERS - 2; i++)
            send_item(KIND_SCHEDULE, 8'(i * 17 + 3), 32'(i + 1), 16'd0, 32'h100);
        send_item(KIND_SCHEDULE, 8'h77, 32'd5, 16'd0, 32'h100);
        send_item(KIND_TICK, 8'h00, 32'd0, 16'd0, 32'h1000);
        drain_results();
        send_item(KIND_CANCEL, 8'h00, 32'd0, tbl_id[MAX_TIMERS / 2 - 1], 32'd0);
        send_item(KIND_TICK, 8'h00, 32'd0, 16'd0, 32'h2000);
        send_item(KIND_CLEAR, 8'h00, 32'd0, 16'd0, 32'd0);
        send_item(KIND_TICK, 8'h00, 32'd0, 16'd0, 32'h3000);
    endtask

    task automatic test_random_traffic();
        int          n;
        int          roll;
        logic [31:0] interval;
        logic [15:0] target;
        sim_now = $urandom();
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) sender_idles = ($urandom_range(0, 3) != 0);
            sim_now += $urandom_range(0, 24);
            if ($urandom_range(0, 49) == 0) sim_now = $urandom();
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                roll = $urandom_range(0, 99);
                if (roll < 70)      interval = $urandom_range(1, 60);
                else if (roll < 85) interval = $urandom_range(1, 2000);
                else if (roll < 95) interval = $urandom();
                else                interval = 32'd0;
                send_item(KIND_SCHEDULE, 8'($urandom_range(0, 255)), interval,
                          16'($urandom_range(0, 65535)), sim_now);
            end else if (roll < 75) begin
                send_item(KIND_TICK, 8'($urandom_range(0, 255)), $urandom(),
                          16'($urandom_range(0, 65535)), sim_now);
            end else if (roll < 95) begin
                if (tbl_count > 0 && $urandom_range(0, 9) < 7)
                    target = tbl_id[$urandom_range(0, tbl_count - 1)];
                else
                    target = 16'($urandom_range(0, 65535));
                send_item(KIND_CANCEL, 8'($urandom_range(0, 255)), $urandom(), target,
                          $urandom());
            end else begin
                send_item(KIND_CLEAR, 8'($urandom_range(0, 255)), $urandom(),
                          16'($urandom_range(0, 65535)), $urandom());
            end
            if ($urandom_range(0, 29) == 0) drain_results();
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            if (o_valid !== 1'b0) begin
                results_checked++;
                if (awaited_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("[%0t] unexpected result: expected none, actual 0x%0h",
                                 $time, o_out);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("result_kind", 32'(want.result_kind), 32'(o_out.result_kind));
                    check_field("assigned_id", 32'(want.assigned_id), 32'(o_out.assigned_id));
                    check_field("table_full",  32'(want.table_full),  32'(o_out.table_full));
                    check_field("fired_event", 32'(want.fired_event), 32'(o_out.fired_event));
                    check_field("last_of_run", 32'(want.last_of_run), 32'(o_out.last_of_run));
                end
            end
            if (o_valid !== 1'b0 || (i_start && o_busy === 1'b0)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[%0t] nothing accepted for %0d cycles", $time, STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_schedule_and_reject();
        test_tick_elapsed();
        drain_results();
        test_cancel_and_full();
        drain_results();
        test_random_traffic();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d items sent, %0d results checked, %0d mismatches",
                 items_sent, results_checked, error_count);
        $display("tb: %0d timer events fired, %0d schedules refused on a full table",
                 fired_total, full_rejects);
        if (error_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

// ===== periodic_timer_table.f =====
rtl/core/ptt_pkg.sv
rtl/core/ptt_ctrl.sv
rtl/core/ptt_datapath.sv
rtl/core/periodic_timer_table.sv
verif/periodic_timer_table_test.sv
